[src/qtue_pkg.sv]
// Shared constants, codes and control types of the Q-table update engine.
`timescale 1ns / 1ps

package qtue_pkg;

  localparam int NUM_STATES  = 4;
  localparam int NUM_ACTIONS = 5;
  localparam int TABLE_SIZE  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W      = $clog2(TABLE_SIZE);
  localparam int COL_W       = $clog2(NUM_ACTIONS);

  localparam int STATE_W  = 2;
  localparam int ACTION_W = 3;
  localparam int Q_W      = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] LR_RESET   = 16'd655;
  localparam logic [CFG_W-1:0] DISC_RESET = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic latch;
    logic scan;
    logic load_old;
    logic calc_target;
    logic calc_old;
    logic calc_new;
    logic write_back;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_col;
    logic is_query;
  } dp_status_t;

endpackage

[src/qtue_ctrl.sv]
// Controller state machine that sequences the row scan and the update arithmetic.
`timescale 1ns / 1ps

module qtue_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  qtue_pkg::dp_status_t  status_i,
  output qtue_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_OLD  = 8'b0000_0100,
    ST_TGT  = 8'b0000_1000,
    ST_PRD1 = 8'b0001_0000,
    ST_PRD2 = 8'b0010_0000,
    ST_WRB  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.last_col) begin
          state_d = status_i.is_query ? ST_DONE : ST_OLD;
        end
      end
      ST_OLD: begin
        cmd_o.load_old = 1'b1;
        state_d        = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.calc_target = 1'b1;
        state_d           = ST_PRD1;
      end
      ST_PRD1: begin
        cmd_o.calc_old = 1'b1;
        state_d        = ST_PRD2;
      end
      ST_PRD2: begin
        cmd_o.calc_new = 1'b1;
        state_d        = ST_WRB;
      end
      ST_WRB: begin
        cmd_o.write_back = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/qtue_datapath.sv]
// Datapath with the Q table, configuration registers, row scan and update arithmetic.
`timescale 1ns / 1ps

module qtue_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  qtue_pkg::ctrl_cmd_t                   cmd_i,
  output qtue_pkg::dp_status_t                  status_o,
  input  logic                                  cfg_we_i,
  input  logic [qtue_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [qtue_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  command_i,
  input  logic [qtue_pkg::STATE_W-1:0]          cur_state_i,
  input  logic [qtue_pkg::STATE_W-1:0]          following_state_i,
  input  logic [qtue_pkg::ACTION_W-1:0]         chosen_action_i,
  input  logic signed [qtue_pkg::Q_W-1:0]       reward_i,
  output logic [qtue_pkg::ACTION_W-1:0]         best_action_o,
  output logic signed [qtue_pkg::Q_W-1:0]       q_value_o
);

  localparam int TGT_W  = 34;
  localparam int OLDP_W = 34;
  localparam int NEWP_W = 51;
  localparam int FULL_W = 56;
  localparam int RES_W  = FULL_W - 32;

  logic [qtue_pkg::Q_W-1:0] mem_q [qtue_pkg::TABLE_SIZE];

  logic [qtue_pkg::CFG_W-1:0] lr_q, disc_q;

  logic                              query_q;
  logic [qtue_pkg::STATE_W-1:0]      cs_q, fs_q;
  logic [qtue_pkg::ACTION_W-1:0]     act_q;
  logic signed [qtue_pkg::Q_W-1:0]   rew_q;
  logic [qtue_pkg::COL_W-1:0]        col_q;
  logic [qtue_pkg::COL_W-1:0]        best_q;
  logic signed [qtue_pkg::Q_W-1:0]   max_q;
  logic signed [qtue_pkg::Q_W-1:0]   old_q;
  logic signed [TGT_W-1:0]           tgt_q;
  logic signed [OLDP_W-1:0]          pold_q;
  logic signed [NEWP_W-1:0]          pnew_q;
  logic signed [qtue_pkg::Q_W-1:0]   res_q;

  logic [qtue_pkg::STATE_W-1:0]      scan_row;
  logic                              scan_ok;
  logic                              tgt_ok;
  logic [qtue_pkg::ADDR_W-1:0]       scan_addr;
  logic [qtue_pkg::ADDR_W-1:0]       tgt_addr;
  logic signed [qtue_pkg::Q_W-1:0]   scan_val;
  logic signed [qtue_pkg::Q_W-1:0]   tgt_val;
  logic [qtue_pkg::ADDR_W-1:0]       rd_addr;
  logic [qtue_pkg::Q_W-1:0]          rd_data;
  logic signed [32:0]                disc_prod;
  logic [16:0]                       one_minus_lr;
  logic signed [FULL_W-1:0]          full;
  logic signed [RES_W-1:0]           rounded;
  logic signed [qtue_pkg::Q_W-1:0]   sat;

  assign scan_row  = query_q ? cs_q : fs_q;
  assign scan_ok   = int'(scan_row) < qtue_pkg::NUM_STATES;
  assign tgt_ok    = (int'(cs_q) < qtue_pkg::NUM_STATES) &&
                     (int'(act_q) < qtue_pkg::NUM_ACTIONS);
  assign scan_addr = qtue_pkg::ADDR_W'(int'(scan_row) * qtue_pkg::NUM_ACTIONS + int'(col_q));
  assign tgt_addr  = qtue_pkg::ADDR_W'(int'(cs_q) * qtue_pkg::NUM_ACTIONS + int'(act_q));
  assign rd_addr   = cmd_i.scan ? scan_addr : tgt_addr;
  assign rd_data   = mem_q[rd_addr];
  assign scan_val  = scan_ok ? $signed(rd_data) : '0;
  assign tgt_val   = tgt_ok ? $signed(rd_data) : '0;

  assign disc_prod    = $signed({{17{1'b0}}, disc_q}) * $signed({{17{max_q[15]}}, max_q});
  assign one_minus_lr = 17'h10000 - {1'b0, lr_q};

  assign full = {{(FULL_W - OLDP_W - 16){pold_q[OLDP_W-1]}}, pold_q, 16'h0000}
              + {{(FULL_W - NEWP_W){pnew_q[NEWP_W-1]}}, pnew_q}
              + 56'sh00_0000_8000_0000;
  assign rounded = full[FULL_W-1:32];

  always_comb begin
    if (rounded > 24'sd32767) begin
      sat = 16'sh7fff;
    end else if (rounded < -24'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = rounded[qtue_pkg::Q_W-1:0];
    end
  end

  assign status_o.last_col = col_q == qtue_pkg::COL_W'(qtue_pkg::NUM_ACTIONS - 1);
  assign status_o.is_query = query_q;

  assign best_action_o = qtue_pkg::ACTION_W'(best_q);
  assign q_value_o     = query_q ? max_q : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < qtue_pkg::TABLE_SIZE; i++) begin
        mem_q[i] <= '0;
      end
    end else if (cmd_i.write_back && tgt_ok) begin
      mem_q[tgt_addr] <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= qtue_pkg::LR_RESET;
      disc_q <= qtue_pkg::DISC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qtue_pkg::CFG_LEARNING_RATE: lr_q   <= cfg_data_i;
        qtue_pkg::CFG_DISCOUNT:      disc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= 1'b0;
      col_q   <= '0;
    end else if (cmd_i.latch) begin
      query_q <= command_i == qtue_pkg::CMD_QUERY;
      col_q   <= '0;
    end else if (cmd_i.scan && !status_o.last_col) begin
      col_q <= col_q + qtue_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cs_q  <= cur_state_i;
      fs_q  <= following_state_i;
      act_q <= chosen_action_i;
      rew_q <= reward_i;
    end
    if (cmd_i.scan) begin
      if (col_q == '0 || scan_val > max_q) begin
        max_q  <= scan_val;
        best_q <= col_q;
      end
    end
    if (cmd_i.load_old) begin
      old_q <= tgt_val;
    end
    if (cmd_i.calc_target) begin
      tgt_q <= {{2{rew_q[qtue_pkg::Q_W-1]}}, rew_q, 16'h0000}
             + {{(TGT_W - 33){disc_prod[32]}}, disc_prod};
    end
    if (cmd_i.calc_old) begin
      pold_q <= $signed({{17{1'b0}}, one_minus_lr}) * $signed({{18{old_q[15]}}, old_q});
    end
    if (cmd_i.calc_new) begin
      pnew_q <= $signed({{35{1'b0}}, lr_q}) * $signed({{17{tgt_q[TGT_W-1]}}, tgt_q});
    end
    if (cmd_i.write_back) begin
      res_q <= tgt_ok ? sat : '0;
    end
  end

endmodule

[src/q_table_update_engine.sv]
// Q-table update engine top level joining the controller and the datapath.
// A query scans the current-state row; an update scans the following-state row, then updates the
// chosen entry. A new start is taken in the cycle after the done strobe, not during a transfer.
// The five-column row scan through the single table read port and three multiply steps set the transfer length.
// Reset clears the whole table to zero at once and restores the register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle with done_o.
`timescale 1ns / 1ps

module q_table_update_engine (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [qtue_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [qtue_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  command_i,
  input  logic [qtue_pkg::STATE_W-1:0]          cur_state_i,
  input  logic [qtue_pkg::STATE_W-1:0]          following_state_i,
  input  logic [qtue_pkg::ACTION_W-1:0]         chosen_action_i,
  input  logic signed [qtue_pkg::Q_W-1:0]       reward_i,
  output logic [qtue_pkg::ACTION_W-1:0]         best_action_o,
  output logic signed [qtue_pkg::Q_W-1:0]       q_value_o
);

  qtue_pkg::ctrl_cmd_t  cmd;
  qtue_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  qtue_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  qtue_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .cur_state_i       (cur_state_i),
    .following_state_i (following_state_i),
    .chosen_action_i   (chosen_action_i),
    .reward_i          (reward_i),
    .best_action_o     (best_action_o),
    .q_value_o         (q_value_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("Accepted transfer did not start work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("Result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("Result strobe outside an active command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_back |=> done_o)
    else $error("Write-back not followed by result");

endmodule
